// File: rtl/afls_pkg.sv
// Shared types, constants and helpers for the adaptive floor level scope.
`timescale 1ns / 1ps

package afls_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int HEIGHT_W = 3;
  localparam int MASK_W   = 7;
  localparam int COL_W    = 6;
  localparam int STEP_W   = 8;
  localparam int SHIFT_W  = 4;
  localparam int WARM_W   = 4;
  localparam int DIVD_W   = SAMPLE_W + HEIGHT_W;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GATE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_RISE_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_DROP_SHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LEVEL       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_TICKS     = 3'd4;

  // Register reset values
  localparam logic [SAMPLE_W-1:0] NOISE_GATE_RST  = 16'd50;
  localparam logic [STEP_W-1:0]   RISE_STEP_RST   = 8'd2;
  localparam logic [SHIFT_W-1:0]  DROP_SHIFT_RST  = 4'd3;
  localparam logic [SAMPLE_W-1:0] IDLE_LEVEL_RST  = 16'd200;
  localparam logic [WARM_W-1:0]   WARMUP_RST      = 4'd7;

  // Bar drawing
  localparam logic [MASK_W-1:0] MASK_FULL     = 7'h7F;
  localparam logic [MASK_W-1:0] MASK_BASELINE = 7'h40;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = 3'd7;

  // Divider status handed back to the sequencer
  typedef struct packed {
    logic                done;
    logic [HEIGHT_W-1:0] quot;
  } afls_div_res_t;

  // Top-aligned bar mask for a height, baseline pixel for zero
  function automatic logic [MASK_W-1:0] bar_mask(input logic [HEIGHT_W-1:0] h);
    logic [MASK_W-1:0] m;
    begin
      if (h == '0) begin
        m = MASK_BASELINE;
      end else begin
        m = MASK_FULL << (HEIGHT_MAX - h);
      end
      return m;
    end
  endfunction

endpackage

// File: rtl/afls_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module afls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 43
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/afls_div.sv
// Radix-2 divider for bar heights: quotient of 7*v by the range, three bits.
`timescale 1ns / 1ps

module afls_div
  import afls_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] dividend,
  input  logic [SAMPLE_W-1:0] divisor,
  output logic                busy,
  output afls_div_res_t       res
);

  logic [SAMPLE_W-1:0] v_r;
  logic [SAMPLE_W-1:0] dvs_r;
  logic [DIVD_W-1:0]   rem_r;
  logic [HEIGHT_W-1:0] q_r;
  logic [1:0]          cnt_r;
  logic                ld_r;
  logic                busy_r;
  logic                done_r;

  logic [DIVD_W-1:0]   trial;
  logic                fits;

  // Shifted divisor for the current quotient bit
  always_comb begin
    trial = {{HEIGHT_W{1'b0}}, dvs_r} << cnt_r;
    fits  = (rem_r >= trial);
  end

  // Control: load, scale by seven, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r   <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ld_r   <= 1'b1;
        busy_r <= 1'b1;
      end else if (ld_r) begin
        ld_r  <= 1'b0;
        cnt_r <= 2'd2;
      end else if (busy_r) begin
        if (cnt_r == 2'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 2'd1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= dividend;
      dvs_r <= divisor;
    end else if (ld_r) begin
      rem_r <= {v_r, {HEIGHT_W{1'b0}}} - {{HEIGHT_W{1'b0}}, v_r};
      q_r   <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - trial;
      end
      q_r <= {q_r[HEIGHT_W-2:0], fits};
    end
  end

  assign busy      = busy_r | ld_r;
  assign res.done  = done_r;
  assign res.quot  = q_r;

endmodule

// File: rtl/adaptive_floor_level_scope_core.sv
// Top level of the adaptive floor level scope: sequencer, ring, floor and output stage.
`timescale 1ns / 1ps

// Usage
// in_*  : one transaction per display tick. in_tdata = amplitude; in_tuser carries
//         transmit, keyed and display flags. in_tready is high only while the
//         sequencer is idle; one tick is worked on at a time.
// out_* : one transaction per display column, oldest sample first, out_tlast on the
//         final column. out_tdata = column, height, pixel mask.
// cfg_* : register write; index 0 noise gate, 1 rise step, 2 drop shift,
//         3 idle level, 4 warm-up ticks. Higher indexes are ignored.
// Sequence: a tick that ends the session or is not keyed is taken in the idle state.
//   A keyed tick with the display off reads and writes back its ring entry.
//   With the display on there follow a min/max walk over the ring memory, the floor
//   and range states, then per column a ring read and a draw, with the divider (load,
//   scale, three quotient bits) between them when the gate passes. The single ring
//   read port and the shared divider make the columns go one after another.
// Reset: configuration returns to defaults, the session is closed and the ring
//   reads as the idle level through per-entry valid bits, with no clearing pass.
// Stall: a column waits in the output register; the column walk halts until
//   out_tready takes it, and no input is accepted meanwhile.

module adaptive_floor_level_scope_core
  import afls_pkg::*;
#(
  parameter int WINDOW = 43
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [15:0] amplitude
  input  logic [2:0]           in_tuser,   // [0] in_transmit, [1] keyed, [2] display_on
  // Output stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [5:0] column, [8:6] height, [15:9] pixel_mask
  output logic                 out_tlast,  // last
  // Configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SC_W  = $clog2(WINDOW + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW - 1);
  localparam logic [SC_W-1:0]  SCAN_END = SC_W'(WINDOW);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_WRITE  = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_FLOOR  = 9'b000001000,
    S_FLOOR2 = 9'b000010000,
    S_RANGE  = 9'b000100000,
    S_CDAT   = 9'b001000000,
    S_CDIV   = 9'b010000000,
    S_COUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [SAMPLE_W-1:0] noise_gate_r;
  logic [STEP_W-1:0]   rise_step_r;
  logic [SHIFT_W-1:0]  drop_shift_r;
  logic [SAMPLE_W-1:0] idle_level_r;
  logic [WARM_W-1:0]   warmup_ticks_r;

  // Session state
  logic                session_r;
  logic [PTR_W-1:0]    wp_r;
  logic [SAMPLE_W-1:0] floor_r;
  logic [WARM_W-1:0]   warm_r;
  logic [SAMPLE_W-1:0] clear_val_r;
  logic [WINDOW-1:0]   vld_r;

  // Per-tick work registers
  logic [SAMPLE_W-1:0] amp_r;
  logic                disp_r;
  logic                store_r;
  logic                vld_q_r;
  logic [SC_W-1:0]     scan_cnt_r;
  logic                sdv_r;
  logic                sfirst_r;
  logic [SAMPLE_W-1:0] mn_r;
  logic [SAMPLE_W-1:0] mx_r;
  logic                gt_r;
  logic [SAMPLE_W-1:0] excess_r;
  logic [SAMPLE_W-1:0] range_r;
  logic [PTR_W-1:0]    rp_r;
  logic [PTR_W-1:0]    col_r;
  logic [HEIGHT_W-1:0] h_r;

  // Output register
  logic                out_tvalid_r;
  logic [15:0]         out_tdata_r;
  logic                out_tlast_r;

  // Combinational
  logic                accept;
  logic                in_tx, in_key, in_disp;
  logic                start;
  logic [PTR_W-1:0]    eff_wp;
  logic [WARM_W-1:0]   eff_warm;
  logic [PTR_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0] ram_q;
  logic [SAMPLE_W-1:0] rd_sample;
  logic [SAMPLE_W-1:0] wr_val;
  logic                ram_we;
  logic [PTR_W-1:0]    wp_inc;
  logic [PTR_W-1:0]    rp_inc;
  logic [SAMPLE_W-1:0] v_val;
  logic                gate_ok;
  logic                out_free;
  logic [SAMPLE_W:0]   rise_sum;
  logic                div_start;
  logic                div_busy;
  afls_div_res_t       div_res;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_tx     = in_tuser[0];
  assign in_key    = in_tuser[1];
  assign in_disp   = in_tuser[2];
  assign start     = accept && in_tx && in_key && !session_r;
  assign eff_wp    = start ? '0 : wp_r;
  assign eff_warm  = start ? '0 : warm_r;
  assign wp_inc    = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
  assign rp_inc    = (rp_r == LAST_IDX) ? '0 : rp_r + 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  // Ring entries never written since session start read as the clear value
  assign rd_sample = vld_q_r ? ram_q : clear_val_r;

  // Select the ring read address
  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = eff_wp;
      S_SCAN:  rd_addr = (scan_cnt_r == SCAN_END) ? '0 : scan_cnt_r[PTR_W-1:0];
      S_COUT:  rd_addr = rp_inc;
      default: rd_addr = rp_r;
    endcase
  end

  // Write-back value: new sample after warm-up, else the entry's current value; zero replaced by idle level
  always_comb begin
    wr_val = store_r ? amp_r : rd_sample;
    if (wr_val == '0) begin
      wr_val = idle_level_r;
    end
  end
  assign ram_we = (state_r == S_WRITE);

  afls_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (wr_val),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Column level above the floor and gate check
  assign v_val     = (rd_sample > floor_r) ? rd_sample - floor_r : '0;
  assign gate_ok   = (range_r >= noise_gate_r) && (range_r != '0);
  assign div_start = (state_r == S_CDAT) && gate_ok;
  assign rise_sum  = {1'b0, floor_r} + {{(SAMPLE_W + 1 - STEP_W){1'b0}}, rise_step_r};

  afls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (v_val),
    .divisor  (range_r),
    .busy     (div_busy),
    .res      (div_res)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept && in_tx && in_key) state_nxt = S_WRITE;
      S_WRITE:  state_nxt = disp_r ? S_SCAN : S_IDLE;
      S_SCAN:   if (sdv_r && scan_cnt_r == SCAN_END) state_nxt = S_FLOOR;
      S_FLOOR:  state_nxt = S_FLOOR2;
      S_FLOOR2: state_nxt = S_RANGE;
      S_RANGE:  state_nxt = S_CDAT;
      S_CDAT:   state_nxt = gate_ok ? S_CDIV : S_COUT;
      S_CDIV:   if (div_res.done) state_nxt = S_COUT;
      S_COUT: begin
        if (out_free) begin
          state_nxt = (col_r == LAST_IDX) ? S_IDLE : S_CDAT;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      noise_gate_r   <= NOISE_GATE_RST;
      rise_step_r    <= RISE_STEP_RST;
      drop_shift_r   <= DROP_SHIFT_RST;
      idle_level_r   <= IDLE_LEVEL_RST;
      warmup_ticks_r <= WARMUP_RST;
      session_r      <= 1'b0;
      wp_r           <= '0;
      floor_r        <= IDLE_LEVEL_RST;
      warm_r         <= '0;
      clear_val_r    <= IDLE_LEVEL_RST;
      vld_r          <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_NOISE_GATE:       noise_gate_r   <= cfg_wdata;
          CFG_FLOOR_RISE_STEP:  rise_step_r    <= cfg_wdata[STEP_W-1:0];
          CFG_FLOOR_DROP_SHIFT: drop_shift_r   <= cfg_wdata[SHIFT_W-1:0];
          CFG_IDLE_LEVEL:       idle_level_r   <= cfg_wdata;
          CFG_WARMUP_TICKS:     warmup_ticks_r <= cfg_wdata[WARM_W-1:0];
          default: ;
        endcase
      end

      // Session open and close
      if (accept && !in_tx) begin
        session_r <= 1'b0;
      end
      if (start) begin
        session_r   <= 1'b1;
        wp_r        <= '0;
        floor_r     <= idle_level_r;
        warm_r      <= '0;
        clear_val_r <= idle_level_r;
        vld_r       <= '0;
      end

      // Write back the ring entry and advance
      if (state_r == S_WRITE) begin
        vld_r[wp_r] <= 1'b1;
        wp_r        <= wp_inc;
        if (!store_r) begin
          warm_r <= warm_r + 1'b1;
        end
      end

      // Floor update
      if (state_r == S_FLOOR2) begin
        if (gt_r) begin
          floor_r <= (excess_r >= floor_r) ? '0 : floor_r - excess_r - 1'b1;
        end else begin
          floor_r <= rise_sum[SAMPLE_W] ? {SAMPLE_W{1'b1}} : rise_sum[SAMPLE_W-1:0];
        end
      end

      // Output register
      if (state_r == S_COUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    vld_q_r <= start ? 1'b0 : vld_r[rd_addr];

    if (accept) begin
      amp_r   <= in_tdata;
      disp_r  <= in_disp;
      store_r <= (eff_warm >= warmup_ticks_r);
    end

    // Min/max walk over the ring
    if (state_r == S_WRITE) begin
      scan_cnt_r <= '0;
      rp_r       <= wp_inc;
    end else if (state_r == S_SCAN && scan_cnt_r != SCAN_END) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
    sdv_r    <= (state_r == S_SCAN) && (scan_cnt_r != SCAN_END);
    sfirst_r <= (scan_cnt_r == '0);
    if (sdv_r) begin
      if (sfirst_r || rd_sample < mn_r) mn_r <= rd_sample;
      if (sfirst_r || rd_sample > mx_r) mx_r <= rd_sample;
    end

    // Floor excess over the minimum
    if (state_r == S_FLOOR) begin
      gt_r     <= (floor_r > mn_r);
      excess_r <= (floor_r - mn_r) >> drop_shift_r;
    end

    // Range against the updated floor
    if (state_r == S_RANGE) begin
      range_r <= (mx_r > floor_r) ? mx_r - floor_r : '0;
      col_r   <= '0;
    end

    // Column height
    if (state_r == S_CDAT && !gate_ok) begin
      h_r <= '0;
    end else if (state_r == S_CDIV && div_res.done) begin
      h_r <= div_res.quot;
    end

    // Draw the column and move to the next
    if (state_r == S_COUT && out_free) begin
      out_tdata_r <= {bar_mask(h_r), h_r, COL_W'(col_r)};
      out_tlast_r <= (col_r == LAST_IDX);
      col_r       <= col_r + 1'b1;
      rp_r        <= rp_inc;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef ASSERT_OFF
  // No new tick while the divider still works on a column
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_busy)
    else $error("input accepted while divider busy");

  // Divider results arrive only when the sequencer waits for them
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_CDIV))
    else $error("divider result outside wait state");

  // Ring pointers stay inside the window; the read pointer is loaded on the write step
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r <= LAST_IDX) &&
    ((state_r == S_IDLE) || (state_r == S_WRITE) || (rp_r <= LAST_IDX)))
    else $error("ring pointer beyond window");

  // Ring write happens in the cycle after a keyed transmit tick
  a_write_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tx && in_key) |=> ram_we)
    else $error("ring write missing after keyed tick");
`endif

endmodule
